// ===== design/ttce_pkg.sv =====
// Shared types and constants for the text terminal cell engine.
// No dependencies; used by the top level text_terminal_cell_engine.
package ttce_pkg;

    // Request and result items
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] char_code;
        logic [3:0] fg_color;
        logic [3:0] bg_color;
        logic [6:0] col_index;
        logic [5:0] row_index;
        logic [8:0] scroll_amount;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] cell_fg;
        logic [3:0] cell_bg;
        logic [7:0] cursor_col;
        logic [5:0] cursor_row;
        logic [8:0] view_back;
        logic [8:0] hist_rows;
    } out_item_t;

    // Operations
    localparam logic [2:0] OP_PUT   = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_UP    = 3'd2;
    localparam logic [2:0] OP_DOWN  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Control characters
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int unsigned TAB_STOP = 4;
    localparam int unsigned RESET_FG = 7;
    localparam int unsigned RESET_BG = 0;

    // Configuration port
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS    = 1'b1;

endpackage

// ===== design/ttce_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ttce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/text_terminal_cell_engine.sv =====
// Top level of the text terminal cell engine: sequencer, cursor and ring state.
// Depends on ttce_pkg and ttce_ram (live grid and scrollback memories).
//
//   channel   direction  handshake            payload
//   in        in         in_valid / in_stall  ttce_pkg::in_item_t
//   out       out        out_valid / out_stall ttce_pkg::out_item_t
//   cfg       in         cfg_write            cfg_index, cfg_data
//
// After reset a clearing pass writes blanks to all MAX_ROWS*MAX_COLS cells of the
// live grid, with in_stall high; configuration writes are taken throughout.
// A viewport read passes through the address step and the registered memory read; a
// character that wraps may first scroll. A scroll reads all MAX_COLS cells of every
// row in use and blanks the columns in use of the last row, one live cell moved per
// cycle through the single read and write port of the live grid.
// One request is in work at a time; a finished result waits in the output
// register while the next request is accepted, and a stalled result holds the
// engine in its completion step.
module text_terminal_cell_engine #(
    parameter int MAX_COLS      = 128,
    parameter int MAX_ROWS      = 64,
    parameter int HISTORY_DEPTH = 256,
    parameter int COLOR_BITS    = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ttce_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ttce_pkg::out_item_t                 out_data,
    input  logic                                cfg_write,
    input  logic [ttce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ttce_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CELL_W     = 8 + 2 * COLOR_BITS;
    localparam int LIVE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int HIST_DEPTH = HISTORY_DEPTH * MAX_COLS;
    localparam int LA = $clog2(LIVE_DEPTH);
    localparam int HA = $clog2(HIST_DEPTH);
    localparam int CI = $clog2(MAX_COLS);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RI = $clog2(MAX_ROWS);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int HI = $clog2(HISTORY_DEPTH);
    localparam int HW = $clog2(HISTORY_DEPTH + 1);
    localparam int PW = $clog2(HISTORY_DEPTH + MAX_ROWS);
    localparam int COLS_RST = (MAX_COLS < 80) ? MAX_COLS : 80;
    localparam int ROWS_RST = (MAX_ROWS < 25) ? MAX_ROWS : 25;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_EXEC   = 11'b000_0000_0100,
        S_GLYPH  = 11'b000_0000_1000,
        S_BSWR   = 11'b000_0001_0000,
        S_SCROLL = 11'b000_0010_0000,
        S_DRAIN  = 11'b000_0100_0000,
        S_BLANK  = 11'b000_1000_0000,
        S_VIEW   = 11'b001_0000_0000,
        S_VREAD  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    // Control state
    state_t           state_reg, state_next;
    logic [CW-1:0]    cols_reg, cols_next;
    logic [RW-1:0]    rows_reg, rows_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RI-1:0]    line_reg, line_next;
    logic [HI-1:0]    head_reg, head_next;
    logic [HW-1:0]    count_reg, count_next;
    logic [HW-1:0]    view_reg, view_next;
    logic [LA-1:0]    clr_reg, clr_next;
    logic [RI-1:0]    sr_row_reg, sr_row_next;
    logic [CI-1:0]    sr_col_reg, sr_col_next;
    logic [CI-1:0]    bl_col_reg, bl_col_next;
    logic             p_valid_reg, p_valid_next;
    logic             ret_glyph_reg, ret_glyph_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    ttce_pkg::in_item_t  req_reg, req_next;
    ttce_pkg::out_item_t out_reg, out_next;
    logic [RI-1:0]       p_row_reg, p_row_next;
    logic [CI-1:0]       p_col_reg, p_col_next;
    logic [LA-1:0]       bs_addr_reg, bs_addr_next;
    logic [CI-1:0]       v_col_reg, v_col_next;
    logic [RI-1:0]       v_row_reg, v_row_next;
    logic [PW-1:0]       v_pos_reg, v_pos_next;
    logic                v_hist_reg, v_hist_next;
    logic [CELL_W-1:0]   cell_reg, cell_next;

    // Memory ports
    logic              live_we, hist_we;
    logic [LA-1:0]     live_waddr, live_raddr;
    logic [HA-1:0]     hist_waddr, hist_raddr;
    logic [CELL_W-1:0] live_wdata, hist_wdata, live_rdata, hist_rdata;

    // Working values
    logic [CELL_W-1:0] blank_cell, glyph_cell;
    logic [CW-1:0]     col_inc;
    logic [HW-1:0]     start_v;
    logic [31:0]       want_v, idx_v, lr_v;
    logic              in_accept, tab_done;
    logic [CW-1:0]     cols_sat;
    logic [RW-1:0]     rows_sat;

    function automatic logic [LA-1:0] live_addr(input logic [RI-1:0] r,
                                                input logic [CI-1:0] c);
        live_addr = LA'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    ttce_ram #(.WIDTH(CELL_W), .DEPTH(LIVE_DEPTH)) u_live (
        .clk     (clk),
        .wr_en   (live_we),
        .wr_addr (live_waddr),
        .wr_data (live_wdata),
        .rd_addr (live_raddr),
        .rd_data (live_rdata)
    );

    ttce_ram #(.WIDTH(CELL_W), .DEPTH(HIST_DEPTH)) u_hist (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (hist_wdata),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign blank_cell = {ttce_pkg::CH_SPACE, COLOR_BITS'(req_reg.fg_color),
                         COLOR_BITS'(req_reg.bg_color)};
    assign glyph_cell = {(req_reg.char_code == ttce_pkg::CH_TAB) ? ttce_pkg::CH_SPACE
                         : req_reg.char_code,
                         COLOR_BITS'(req_reg.fg_color), COLOR_BITS'(req_reg.bg_color)};
    assign col_inc  = col_reg + CW'(1);
    // tab ends at a stop, at a narrow line's end, or after one cell for a plain glyph
    assign tab_done = (req_reg.char_code != ttce_pkg::CH_TAB)
                   || ((32'(cols_reg) < ttce_pkg::TAB_STOP) && (32'(col_inc) >= 32'(cols_reg)))
                   || ((32'(col_inc) % ttce_pkg::TAB_STOP) == 0);

    // Saturated register values for the configuration port
    always_comb
    begin
        if (cfg_data == '0)
            cols_sat = CW'(1);
        else if (32'(cfg_data) > MAX_COLS)
            cols_sat = CW'(MAX_COLS);
        else
            cols_sat = CW'(cfg_data);
        if (cfg_data[6:0] == '0)
            rows_sat = RW'(1);
        else if (32'(cfg_data[6:0]) > MAX_ROWS)
            rows_sat = RW'(MAX_ROWS);
        else
            rows_sat = RW'(cfg_data[6:0]);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        col_next       = col_reg;
        line_next      = line_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        view_next      = view_reg;
        clr_next       = clr_reg;
        sr_row_next    = sr_row_reg;
        sr_col_next    = sr_col_reg;
        bl_col_next    = bl_col_reg;
        p_valid_next   = 1'b0;
        ret_glyph_next = ret_glyph_reg;
        req_next       = req_reg;
        p_row_next     = p_row_reg;
        p_col_next     = p_col_reg;
        bs_addr_next   = bs_addr_reg;
        v_col_next     = v_col_reg;
        v_row_next     = v_row_reg;
        v_pos_next     = v_pos_reg;
        v_hist_next    = v_hist_reg;
        cell_next      = cell_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        start_v        = '0;
        want_v         = '0;
        idx_v          = '0;
        lr_v           = '0;
        live_raddr     = '0;
        hist_raddr     = '0;
        live_we        = 1'b0;
        live_waddr     = '0;
        live_wdata     = '0;
        hist_we        = 1'b0;
        hist_waddr     = '0;
        hist_wdata     = '0;

        // scroll pipeline: the cell read last cycle moves up a row or into the ring
        if (p_valid_reg)
        begin
            if (p_row_reg == '0)
            begin
                hist_we    = 1'b1;
                hist_waddr = HA'(32'(head_reg) * MAX_COLS + 32'(p_col_reg));
                hist_wdata = live_rdata;
            end
            else
            begin
                live_we    = 1'b1;
                live_waddr = live_addr(p_row_reg - RI'(1), p_col_reg);
                live_wdata = live_rdata;
            end
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                live_we    = 1'b1;
                live_waddr = clr_reg;
                live_wdata = {ttce_pkg::CH_SPACE, COLOR_BITS'(ttce_pkg::RESET_FG),
                              COLOR_BITS'(ttce_pkg::RESET_BG)};
                clr_next   = clr_reg + LA'(1);
                if (32'(clr_reg) == LIVE_DEPTH - 1)
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next   = in_data;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                cell_next  = '0;
                state_next = S_DONE;
                unique case (req_reg.opcode)
                    ttce_pkg::OP_PUT:
                    begin
                        view_next = '0;
                        if (req_reg.char_code == ttce_pkg::CH_NL)
                        begin
                            col_next = '0;
                            if (32'(line_reg) + 1 >= 32'(rows_reg))
                            begin
                                line_next      = RI'(rows_reg - RW'(1));
                                ret_glyph_next = 1'b0;
                                sr_row_next    = '0;
                                sr_col_next    = '0;
                                state_next     = S_SCROLL;
                            end
                            else
                            begin
                                line_next = line_reg + RI'(1);
                            end
                        end
                        else if (req_reg.char_code == ttce_pkg::CH_CR)
                        begin
                            col_next = '0;
                        end
                        else if (req_reg.char_code == ttce_pkg::CH_BS)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next     = col_reg - CW'(1);
                                live_raddr   = live_addr(line_reg, CI'(col_reg - CW'(1)));
                                bs_addr_next = live_raddr;
                                state_next   = S_BSWR;
                            end
                        end
                        else
                        begin
                            state_next = S_GLYPH;
                        end
                    end
                    ttce_pkg::OP_SET:
                    begin
                        col_next  = (32'(req_reg.col_index) >= 32'(cols_reg))
                                  ? cols_reg - CW'(1) : CW'(req_reg.col_index);
                        line_next = (32'(req_reg.row_index) >= 32'(rows_reg))
                                  ? RI'(rows_reg - RW'(1)) : RI'(req_reg.row_index);
                    end
                    ttce_pkg::OP_UP:
                    begin
                        if (req_reg.scroll_amount != '0 && count_reg != '0)
                        begin
                            want_v    = 32'(view_reg) + 32'(req_reg.scroll_amount);
                            view_next = (want_v > 32'(count_reg)) ? count_reg : HW'(want_v);
                        end
                    end
                    ttce_pkg::OP_DOWN:
                    begin
                        if (req_reg.scroll_amount != '0 && view_reg != '0)
                        begin
                            view_next = (32'(req_reg.scroll_amount) > 32'(view_reg))
                                      ? '0 : HW'(32'(view_reg) - 32'(req_reg.scroll_amount));
                        end
                    end
                    ttce_pkg::OP_READ:
                    begin
                        v_col_next = (32'(req_reg.col_index) >= 32'(cols_reg))
                                   ? CI'(cols_reg - CW'(1)) : CI'(req_reg.col_index);
                        v_row_next = (32'(req_reg.row_index) >= 32'(rows_reg))
                                   ? RI'(rows_reg - RW'(1)) : RI'(req_reg.row_index);
                        start_v    = (count_reg >= view_reg) ? count_reg - view_reg : '0;
                        v_pos_next = PW'(32'(start_v) + 32'(v_row_next));
                        state_next = S_VIEW;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // one cell of a glyph or a tab, with wrap first when the line is full
            S_GLYPH:
            begin
                if (32'(col_reg) >= 32'(cols_reg))
                begin
                    col_next = '0;
                    if (32'(line_reg) + 1 >= 32'(rows_reg))
                    begin
                        line_next      = RI'(rows_reg - RW'(1));
                        ret_glyph_next = 1'b1;
                        sr_row_next    = '0;
                        sr_col_next    = '0;
                        state_next     = S_SCROLL;
                    end
                    else
                    begin
                        line_next = line_reg + RI'(1);
                    end
                end
                else
                begin
                    live_we    = 1'b1;
                    live_waddr = live_addr(line_reg, CI'(col_reg));
                    live_wdata = glyph_cell;
                    col_next   = col_inc;
                    if (tab_done)
                        state_next = S_DONE;
                end
            end

            // backspace: blank the character, keep the colours just read
            S_BSWR:
            begin
                live_we    = 1'b1;
                live_waddr = bs_addr_reg;
                live_wdata = {ttce_pkg::CH_SPACE, live_rdata[CELL_W-9:0]};
                state_next = S_DONE;
            end

            // read every live cell of the active rows, row 0 to the ring
            S_SCROLL:
            begin
                live_raddr   = live_addr(sr_row_reg, sr_col_reg);
                p_valid_next = 1'b1;
                p_row_next   = sr_row_reg;
                p_col_next   = sr_col_reg;
                if (32'(sr_col_reg) == MAX_COLS - 1)
                begin
                    sr_col_next = '0;
                    if (32'(sr_row_reg) + 1 == 32'(rows_reg))
                        state_next = S_DRAIN;
                    else
                        sr_row_next = sr_row_reg + RI'(1);
                end
                else
                begin
                    sr_col_next = sr_col_reg + CI'(1);
                end
            end

            S_DRAIN:
            begin
                bl_col_next = '0;
                state_next  = S_BLANK;
            end

            // blank the active columns of the last row, then advance the ring
            S_BLANK:
            begin
                live_we     = 1'b1;
                live_waddr  = live_addr(RI'(rows_reg - RW'(1)), bl_col_reg);
                live_wdata  = blank_cell;
                bl_col_next = bl_col_reg + CI'(1);
                if (32'(bl_col_reg) + 1 == 32'(cols_reg))
                begin
                    head_next  = (32'(head_reg) == HISTORY_DEPTH - 1) ? '0 : head_reg + HI'(1);
                    if (32'(count_reg) < HISTORY_DEPTH)
                        count_next = count_reg + HW'(1);
                    state_next = ret_glyph_reg ? S_GLYPH : S_DONE;
                end
            end

            // map the viewport row onto the ring or the live grid
            S_VIEW:
            begin
                v_hist_next = 1'b0;
                if (view_reg == '0)
                begin
                    live_raddr = live_addr(v_row_reg, v_col_reg);
                end
                else if (32'(v_pos_reg) < 32'(count_reg))
                begin
                    idx_v = 32'(head_reg) + HISTORY_DEPTH - 32'(count_reg) + 32'(v_pos_reg);
                    if (idx_v >= HISTORY_DEPTH)
                        idx_v = idx_v - HISTORY_DEPTH;
                    hist_raddr  = HA'(idx_v * MAX_COLS + 32'(v_col_reg));
                    v_hist_next = 1'b1;
                end
                else
                begin
                    lr_v = 32'(v_pos_reg) - 32'(count_reg);
                    if (lr_v >= 32'(rows_reg))
                        lr_v = 32'(rows_reg) - 1;
                    live_raddr = live_addr(RI'(lr_v), v_col_reg);
                end
                state_next = S_VREAD;
            end

            S_VREAD:
            begin
                cell_next  = v_hist_reg ? hist_rdata : live_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.cell_char    = cell_reg[CELL_W-1 -: 8];
                    out_next.cell_fg      = 4'(cell_reg[2*COLOR_BITS-1 -: COLOR_BITS]);
                    out_next.cell_bg      = 4'(cell_reg[COLOR_BITS-1:0]);
                    out_next.cursor_col   = 8'(col_reg);
                    out_next.cursor_row   = 6'(line_reg);
                    out_next.view_back    = 9'(view_reg);
                    out_next.hist_rows    = 9'(count_reg);
                    out_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes must come only while idle, not enforced; the cursor is clamped at once
        if (cfg_write)
        begin
            unique case (cfg_index)
                ttce_pkg::REG_COLUMNS:
                begin
                    cols_next = cols_sat;
                    if (32'(col_reg) >= 32'(cols_sat))
                        col_next = cols_sat - CW'(1);
                end
                ttce_pkg::REG_ROWS:
                begin
                    rows_next = rows_sat;
                    if (32'(line_reg) >= 32'(rows_sat))
                        line_next = RI'(rows_sat - RW'(1));
                    // a cursor parked at the line end is pulled back too
                    if (32'(col_reg) >= 32'(cols_reg))
                        col_next = cols_reg - CW'(1);
                end
                default:
                begin
                    cols_next = cols_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cols_reg      <= CW'(COLS_RST);
            rows_reg      <= RW'(ROWS_RST);
            col_reg       <= '0;
            line_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            view_reg      <= '0;
            clr_reg       <= '0;
            sr_row_reg    <= '0;
            sr_col_reg    <= '0;
            bl_col_reg    <= '0;
            p_valid_reg   <= 1'b0;
            ret_glyph_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            view_reg      <= view_next;
            clr_reg       <= clr_next;
            sr_row_reg    <= sr_row_next;
            sr_col_reg    <= sr_col_next;
            bl_col_reg    <= bl_col_next;
            p_valid_reg   <= p_valid_next;
            ret_glyph_reg <= ret_glyph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        out_reg     <= out_next;
        p_row_reg   <= p_row_next;
        p_col_reg   <= p_col_next;
        bs_addr_reg <= bs_addr_next;
        v_col_reg   <= v_col_next;
        v_row_reg   <= v_row_next;
        v_pos_reg   <= v_pos_next;
        v_hist_reg  <= v_hist_next;
        cell_reg    <= cell_next;
    end

    // Checks
    a_line_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(line_reg) < 32'(rows_reg))
        else $error("cursor row beyond the active rows");

    a_view_capped: assert property (@(posedge clk) disable iff (!rst_n)
        view_reg <= count_reg)
        else $error("view offset beyond the ring count");

    a_ring_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= HISTORY_DEPTH)
        else $error("ring count beyond the history depth");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLANK || state_reg == S_GLYPH || state_reg == S_BSWR) |-> !p_valid_reg)
        else $error("scroll copy overlaps another live grid write");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the completion state");

endmodule
